@@ sv/bba_pkg.sv @@
`default_nettype none
package bba_pkg;

    localparam int MAX_DEPTH   = 10;
    localparam int NODE_W      = MAX_DEPTH + 1;
    localparam int LVL_W       = 4;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;
    localparam int MEM_DEPTH   = (1 << NODE_W) / WORD_W;
    localparam int ADDR_W      = NODE_W - BIT_W;
    localparam int REQ_W       = 24;
    localparam int MINB_W      = 17;
    localparam int BLK_W       = MINB_W + MAX_DEPTH;
    localparam int OFFSET_W    = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [REQ_W:0]    HEADER_BYTES  = 25'd4;
    localparam logic [MINB_W-1:0] MIN_BLOCK_LOW = 17'd8;

    localparam logic [LVL_W-1:0]  LEVELS_RST = 4'd10;
    localparam logic [MINB_W-1:0] MINB_RST   = 17'd64;
    localparam logic [REQ_W-1:0]  MAXREQ_RST = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVELS  = 2'd0,
        CFG_MINB    = 2'd1,
        CFG_MAXREQ  = 2'd2,
        CFG_UNUSED  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

endpackage
`default_nettype wire

@@ sv/bba_req_if.sv @@
`default_nettype none
interface bba_req_if
    import bba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [REQ_W-1:0]  request_bytes;
    logic [NODE_W-1:0] node_to_free;

    modport source (output valid, kind, request_bytes, node_to_free, input ready);
    modport sink   (input valid, kind, request_bytes, node_to_free, output ready);
endinterface
`default_nettype wire

@@ sv/bba_rsp_if.sv @@
`default_nettype none
interface bba_rsp_if
    import bba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                ok;
    logic [1:0]          status;
    logic [NODE_W-1:0]   node;
    logic [LVL_W-1:0]    block_level;
    logic [OFFSET_W-1:0] block_offset;

    modport source (output valid, ok, status, node, block_level, block_offset,
                    input ready);
    modport sink   (input valid, ok, status, node, block_level, block_offset,
                    output ready);
endinterface
`default_nettype wire

@@ sv/bba_cfg_if.sv @@
`default_nettype none
interface bba_cfg_if
    import bba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/buddy_bitmap_allocator_top.sv @@
// Buddy allocator over a bitmap tree held in a 64 x 32 bit RAM (one bit per node).
// Allocate: size search, level scan, then each ancestor and subtree word is read and written
// back; free: subtree words are cleared, then the climb clears parents while the buddy is
// free and stops at a used buddy; a refused transaction goes straight to the result.
// One transaction at a time; the next is taken once the last result is in the result register.
// Reset (rst_n low, async) restores the registers, then a pass clears all 64 bitmap words.
`default_nettype none
module buddy_bitmap_allocator_top
    import bba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SIZE, S_SCAN_RD, S_SCAN_CHK, S_ANC_RD, S_ANC_WR,
        S_SUB_RD, S_SUB_WR, S_BUD_RD, S_BUD_CHK, S_PAR_RD, S_PAR_WR, S_MUL, S_DONE
    } state_t;

    state_t               state_reg;
    logic [LVL_W-1:0]     levels_reg;
    logic [MINB_W-1:0]    minb_reg;
    logic [REQ_W-1:0]     maxreq_reg;
    logic [ADDR_W-1:0]    clr_reg;
    logic [REQ_W:0]       size_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [LVL_W-1:0]     k_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [LVL_W-1:0]     d_reg;
    logic [NODE_W-1:0]    first_reg, last_reg, lo_reg, hi_reg;
    logic [ADDR_W-1:0]    w_reg;
    logic [NODE_W-1:0]    node_reg, anc_reg;
    logic                 val_reg;
    logic                 ok_reg;
    status_t              status_reg;
    logic [NODE_W-1:0]    rnode_reg;
    logic [LVL_W-1:0]     rlvl_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 rsp_valid_reg;
    logic                 rsp_ok_reg;
    logic [1:0]           rsp_status_reg;
    logic [NODE_W-1:0]    rsp_node_reg;
    logic [LVL_W-1:0]     rsp_lvl_reg;
    logic [OFFSET_W-1:0]  rsp_offset_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_W-1:0]    mem_wdata, mem_rdata;

    logic [LVL_W-1:0]     depth;
    logic [MINB_W-1:0]    minb_eff;
    logic [NODE_W:0]      tree_nodes;
    logic [REQ_W:0]       req_size;
    logic [LVL_W-1:0]     req_lvl;
    logic [NODE_W-1:0]    buddy, parent;
    logic [WORD_W-1:0]    node_bit, anc_bit, buddy_bit;
    logic [WORD_W-1:0]    scan_free, sub_mask;
    logic [BIT_W-1:0]     scan_pos;
    logic [NODE_W-1:0]    level_t_first, level_t_last;
    logic [LVL_W-1:0]     size_lvl;
    logic [NODE_W-2:0]    pos;
    logic [BLK_W+NODE_W-2:0] prod;
    logic                 rsp_free;

    // Mask of the bits of word w that fall inside node range lo..hi.
    function automatic logic [WORD_W-1:0] range_mask(
        input logic [ADDR_W-1:0] w,
        input logic [NODE_W-1:0] lo,
        input logic [NODE_W-1:0] hi
    );
        logic [WORD_W-1:0] m_lo;
        logic [WORD_W-1:0] m_hi;
        m_lo = (w == lo[NODE_W-1:BIT_W]) ? ({WORD_W{1'b1}} << lo[BIT_W-1:0])
                                         : {WORD_W{1'b1}};
        m_hi = (w == hi[NODE_W-1:BIT_W])
             ? ({WORD_W{1'b1}} >> (5'd31 - hi[BIT_W-1:0])) : {WORD_W{1'b1}};
        return m_lo & m_hi;
    endfunction

    // Register-derived operating values
    assign depth      = (levels_reg > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : levels_reg;
    assign minb_eff   = (minb_reg < MIN_BLOCK_LOW) ? MIN_BLOCK_LOW : minb_reg;
    assign tree_nodes = (NODE_W+1)'(((NODE_W+1)'(2) << depth) - (NODE_W+1)'(1));
    assign req_size   = {1'b0, req.request_bytes} + HEADER_BYTES;

    // Level of the node to free: position of the top bit of node + 1
    always_comb
    begin
        logic [NODE_W-1:0] x;
        x = req.node_to_free + NODE_W'(1);
        req_lvl = '0;
        for (int i = 0; i < NODE_W; i++)
        begin
            if (x[i])
            begin
                req_lvl = LVL_W'(i);
            end
        end
    end

    // Tree neighbors and single-bit masks
    assign buddy     = node_reg[0] ? node_reg + NODE_W'(1) : node_reg - NODE_W'(1);
    assign parent    = NODE_W'((node_reg - NODE_W'(1)) >> 1);
    assign node_bit  = WORD_W'(1) << node_reg[BIT_W-1:0];
    assign anc_bit   = WORD_W'(1) << anc_reg[BIT_W-1:0];
    assign buddy_bit = WORD_W'(1) << buddy[BIT_W-1:0];
    assign sub_mask  = range_mask(w_reg, lo_reg, hi_reg);

    // Level search result
    assign size_lvl      = depth - k_reg;
    assign level_t_first = NODE_W'(((NODE_W+1)'(1) << size_lvl) - (NODE_W+1)'(1));
    assign level_t_last  = NODE_W'(((NODE_W+1)'(2) << size_lvl) - (NODE_W+1)'(2));

    // First free node in the scanned word
    assign scan_free = ~mem_rdata & range_mask(w_reg, first_reg, last_reg);
    always_comb
    begin
        scan_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (scan_free[i])
            begin
                scan_pos = BIT_W'(i);
            end
        end
    end

    // Byte offset of the allocated block
    assign pos  = (NODE_W-1)'(node_reg - first_reg);
    assign prod = pos * blk_reg;

    // RAM port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = w_reg;
        mem_wdata = mem_rdata;
        mem_raddr = w_reg;
        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            S_ANC_RD:   mem_raddr = anc_reg[NODE_W-1:BIT_W];
            S_ANC_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = anc_reg[NODE_W-1:BIT_W];
                mem_wdata = mem_rdata | anc_bit;
            end
            S_SUB_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = val_reg ? (mem_rdata | sub_mask) : (mem_rdata & ~sub_mask);
            end
            S_BUD_RD:   mem_raddr = buddy[NODE_W-1:BIT_W];
            S_PAR_RD:   mem_raddr = node_reg[NODE_W-1:BIT_W];
            S_PAR_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = node_reg[NODE_W-1:BIT_W];
                mem_wdata = mem_rdata & ~node_bit;
            end
            default:
            begin
            end
        endcase
    end

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = rsp_ok_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.node         = rsp_node_reg;
    assign rsp.block_level  = rsp_lvl_reg;
    assign rsp.block_offset = rsp_offset_reg;
    assign rsp_free         = !rsp_valid_reg || rsp.ready;

    // Sequencer, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            levels_reg     <= LEVELS_RST;
            minb_reg       <= MINB_RST;
            maxreq_reg     <= MAXREQ_RST;
            clr_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            // configuration transaction
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_LEVELS: levels_reg <= cfg.data[LVL_W-1:0];
                    CFG_MINB:   minb_reg   <= cfg.data[MINB_W-1:0];
                    CFG_MAXREQ: maxreq_reg <= cfg.data[REQ_W-1:0];
                    CFG_UNUSED:
                    begin
                    end
                endcase
            end

            // result taken; S_DONE reloads the register itself
            if (rsp_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        rnode_reg  <= '0;
                        rlvl_reg   <= '0;
                        offset_reg <= '0;
                        if (req.kind == KIND_ALLOC)
                        begin
                            ok_reg   <= 1'b0;
                            size_reg <= req_size;
                            blk_reg  <= BLK_W'(minb_eff);
                            k_reg    <= '0;
                            if (req_size > {1'b0, maxreq_reg})
                            begin
                                status_reg <= ST_TOO_LARGE;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                state_reg  <= S_SIZE;
                            end
                        end
                        else if ({1'b0, req.node_to_free} >= tree_nodes)
                        begin
                            ok_reg     <= 1'b0;
                            status_reg <= ST_BAD_INDEX;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            ok_reg     <= 1'b1;
                            status_reg <= ST_OK;
                            node_reg   <= req.node_to_free;
                            lo_reg     <= req.node_to_free;
                            hi_reg     <= req.node_to_free;
                            w_reg      <= req.node_to_free[NODE_W-1:BIT_W];
                            d_reg      <= req_lvl;
                            val_reg    <= 1'b0;
                            state_reg  <= S_SUB_RD;
                        end
                    end
                end
                // smallest block size that holds the request, up to the root, one doubling a cycle
                S_SIZE:
                begin
                    if (blk_reg < BLK_W'(size_reg) && k_reg < depth)
                    begin
                        blk_reg <= blk_reg << 1;
                        k_reg   <= k_reg + LVL_W'(1);
                    end
                    else
                    begin
                        lvl_reg   <= size_lvl;
                        first_reg <= level_t_first;
                        last_reg  <= level_t_last;
                        w_reg     <= level_t_first[NODE_W-1:BIT_W];
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:  state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    if (|scan_free)
                    begin
                        node_reg  <= {w_reg, scan_pos};
                        anc_reg   <= {w_reg, scan_pos};
                        state_reg <= S_ANC_RD;
                    end
                    else if (w_reg == last_reg[NODE_W-1:BIT_W])
                    begin
                        status_reg <= ST_NO_FREE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        w_reg     <= w_reg + ADDR_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                // mark the node and its ancestors
                S_ANC_RD:   state_reg <= S_ANC_WR;
                S_ANC_WR:
                begin
                    if (anc_reg == '0)
                    begin
                        lo_reg    <= node_reg;
                        hi_reg    <= node_reg;
                        w_reg     <= node_reg[NODE_W-1:BIT_W];
                        d_reg     <= lvl_reg;
                        val_reg   <= 1'b1;
                        state_reg <= S_SUB_RD;
                    end
                    else
                    begin
                        anc_reg   <= NODE_W'((anc_reg - NODE_W'(1)) >> 1);
                        state_reg <= S_ANC_RD;
                    end
                end
                // subtree fill or clear, one level range at a time
                S_SUB_RD:   state_reg <= S_SUB_WR;
                S_SUB_WR:
                begin
                    if (w_reg == hi_reg[NODE_W-1:BIT_W])
                    begin
                        if (d_reg == depth)
                        begin
                            if (val_reg)
                            begin
                                state_reg <= S_MUL;
                            end
                            else if (node_reg == '0)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_BUD_RD;
                            end
                        end
                        else
                        begin
                            d_reg     <= d_reg + LVL_W'(1);
                            lo_reg    <= {lo_reg[NODE_W-2:0], 1'b1};
                            hi_reg    <= {hi_reg[NODE_W-2:0], 1'b0} + NODE_W'(2);
                            w_reg     <= lo_reg[NODE_W-2:BIT_W-1];
                            state_reg <= S_SUB_RD;
                        end
                    end
                    else
                    begin
                        w_reg     <= w_reg + ADDR_W'(1);
                        state_reg <= S_SUB_RD;
                    end
                end
                // merge climb after a free
                S_BUD_RD:   state_reg <= S_BUD_CHK;
                S_BUD_CHK:
                begin
                    if ((mem_rdata & buddy_bit) != '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        node_reg  <= parent;
                        state_reg <= S_PAR_RD;
                    end
                end
                S_PAR_RD:   state_reg <= S_PAR_WR;
                S_PAR_WR:   state_reg <= (node_reg == '0) ? S_DONE : S_BUD_RD;
                S_MUL:
                begin
                    ok_reg     <= 1'b1;
                    rnode_reg  <= node_reg;
                    rlvl_reg   <= lvl_reg;
                    offset_reg <= prod[OFFSET_W-1:0];
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_ok_reg     <= ok_reg;
                        rsp_status_reg <= status_reg;
                        rsp_node_reg   <= rnode_reg;
                        rsp_lvl_reg    <= rlvl_reg;
                        rsp_offset_reg <= offset_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a taken request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous still in work");

    // ok and status agree on every delivered result
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.ok == (rsp.status == ST_OK)))
        else $error("ok flag disagrees with status");

    // the level scan never runs past the last word of its level
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CHK |-> w_reg <= last_reg[NODE_W-1:BIT_W])
        else $error("level scan beyond level end");
`endif

endmodule
`default_nettype wire

@@ sv/bba_ram.sv @@
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ test/bba_alloc_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module bba_alloc_checker
    import bba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bba_req_if.sink   req_mon,
    bba_rsp_if.sink   rsp_mon,
    bba_cfg_if.sink   cfg_mon,
    output int        error_count,
    output int        pending_count
);

    typedef struct packed {
        logic                ok;
        status_t             status;
        logic [NODE_W-1:0]   node;
        logic [LVL_W-1:0]    block_level;
        logic [OFFSET_W-1:0] block_offset;
    } alloc_result_t;

    localparam int TREE_NODES = (2 << MAX_DEPTH) - 1;

    logic                used_map [TREE_NODES];
    logic [LVL_W-1:0]    levels_reg;
    logic [MINB_W-1:0]   minb_reg;
    logic [REQ_W-1:0]    maxreq_reg;
    alloc_result_t       expected_results [$];

    function automatic int tree_depth();
        return (levels_reg > MAX_DEPTH) ? MAX_DEPTH : int'(levels_reg);
    endfunction

    // set or clear a node and everything below it within the tree in use
    function automatic void fill_subtree(int n, int lvl, int depth, logic v);
        int first;
        int cnt;
        for (int d = lvl; d <= depth; d++)
        begin
            first = ((n + 1) << (d - lvl)) - 1;
            cnt   = 1 << (d - lvl);
            for (int i = 0; i < cnt; i++)
                if (first + i < TREE_NODES)
                    used_map[first + i] = v;
        end
    endfunction

    function automatic int node_level(int n);
        int l;
        int x;
        l = 0;
        x = n + 1;
        while (x > 1)
        begin
            x = x >> 1;
            l++;
        end
        return l;
    endfunction

    // next result for one request transaction; updates the bitmap
    function automatic alloc_result_t predict_alloc(logic kind, logic [REQ_W-1:0] bytes,
                                                     logic [NODE_W-1:0] idx_in);
        alloc_result_t r;
        int depth;
        longint sz;
        longint mb;
        int k;
        int t;
        int first;
        int j;
        int a;
        int idx;
        int buddy;
        bit found;
        r = '0;
        r.status = ST_OK;
        depth = tree_depth();
        if (kind == KIND_ALLOC)
        begin
            sz = longint'(bytes) + 4;
            if (sz > longint'(maxreq_reg))
                r.status = ST_TOO_LARGE;
            else
            begin
                mb = (minb_reg < MIN_BLOCK_LOW) ? 8 : longint'(minb_reg);
                k = 0;
                while ((mb << k) < sz && k < 40)
                    k++;
                t = (k > depth) ? 0 : depth - k;
                first = (1 << t) - 1;
                found = 0;
                for (j = first; j < (2 << t) - 1; j++)
                    if (!used_map[j])
                    begin
                        found = 1;
                        break;
                    end
                if (!found)
                    r.status = ST_NO_FREE;
                else
                begin
                    a = j;
                    used_map[a] = 1'b1;
                    while (a != 0)
                    begin
                        a = (a - 1) >> 1;
                        used_map[a] = 1'b1;
                    end
                    fill_subtree(j, t, depth, 1'b1);
                    r.ok = 1'b1;
                    r.node = j[NODE_W-1:0];
                    r.block_level = t[LVL_W-1:0];
                    r.block_offset = OFFSET_W'(longint'(j - first) * (mb << (depth - t)));
                end
            end
        end
        else
        begin
            idx = int'(idx_in);
            if (idx >= (2 << depth) - 1)
                r.status = ST_BAD_INDEX;
            else
            begin
                fill_subtree(idx, node_level(idx), depth, 1'b0);
                // merge upward while the buddy is free
                while (idx != 0)
                begin
                    buddy = idx[0] ? idx + 1 : idx - 1;
                    if (buddy < TREE_NODES && used_map[buddy])
                        break;
                    idx = (idx - 1) >> 1;
                    used_map[idx] = 1'b0;
                end
                r.ok = 1'b1;
            end
        end
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // monitor: config writes, requests, results
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t exp_r;
        alloc_result_t act_r;
        if (!rst_n)
        begin
            for (int i = 0; i < TREE_NODES; i++)
                used_map[i] = 1'b0;
            levels_reg  = LEVELS_RST;
            minb_reg    = MINB_RST;
            maxreq_reg  = MAXREQ_RST;
            error_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_idx_t'(cfg_mon.index))
                    CFG_LEVELS: levels_reg = cfg_mon.data[LVL_W-1:0];
                    CFG_MINB:   minb_reg   = cfg_mon.data[MINB_W-1:0];
                    CFG_MAXREQ: maxreq_reg = cfg_mon.data[REQ_W-1:0];
                    default:    ;
                endcase
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                act_r.ok = rsp_mon.ok;
                act_r.status = status_t'(rsp_mon.status);
                act_r.node = rsp_mon.node;
                act_r.block_level = rsp_mon.block_level;
                act_r.block_offset = rsp_mon.block_offset;
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: unexpected result %p", $realtime, act_r);
                    error_count <= error_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== act_r)
                    begin
                        if (error_count < 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, exp_r, act_r);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                expected_results.push_back(predict_alloc(req_mon.kind,
                                           req_mon.request_bytes, req_mon.node_to_free));
        end
    end

endmodule
`default_nettype wire

@@ test/buddy_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module buddy_bitmap_allocator_top_tb;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    int   error_count;
    int   pending_count;
    int   cycle_count;
    bit   idle_off;
    bit   hold_req;
    bit   hold_done;
    int   hold_cycles;
    logic [NODE_W-1:0] live_nodes [$];

    bba_req_if req ();
    bba_rsp_if rsp ();
    bba_cfg_if cfg ();

    buddy_bitmap_allocator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    bba_alloc_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mon       (req.sink),
        .rsp_mon       (rsp.sink),
        .cfg_mon       (cfg.sink),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // capture granted nodes so later frees mostly hit real blocks
    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready && rsp.ok && rsp.block_offset !== 'x
            && live_nodes.size() < 64 && !(rsp.node == '0 && rsp.block_level == '0
            && rsp.block_offset == '0 && rsp.status == ST_OK && 0))
            live_nodes.push_back(rsp.node);

    // result side: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_req && !hold_done)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles <= 400;
            hold_done   <= 1'b1;
        end
        else if (!idle_off && $urandom_range(0, 5) == 0)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
    end

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // one request transaction; random gap bursts before it
    task automatic send_req(logic kind, logic [REQ_W-1:0] bytes, logic [NODE_W-1:0] idx);
        int gap;
        if (!idle_off && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            req.valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.kind          <= kind;
        req.request_bytes <= bytes;
        req.node_to_free  <= idx;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        int waited;
        req.valid <= 1'b0;
        waited = 0;
        while (pending_count != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (300)
            @(negedge clk);
    endtask

    // random request mix: mostly allocations of modest sizes and frees of live nodes
    task automatic random_req();
        int sel;
        logic [NODE_W-1:0] n;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            send_req(KIND_ALLOC, REQ_W'($urandom_range(0, 3000)), NODE_W'($urandom));
        else if (sel < 52)
            send_req(KIND_ALLOC, REQ_W'($urandom), NODE_W'($urandom));
        else if (sel < 85 && live_nodes.size() > 0)
        begin
            n = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
            send_req(KIND_FREE, REQ_W'($urandom), n);
        end
        else
            send_req(KIND_FREE, REQ_W'($urandom), NODE_W'($urandom_range(0, 2047)));
    endtask

    initial
    begin
        idle_off    = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_ALLOC;
        req.request_bytes = '0;
        req.node_to_free = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_LEVELS;
        cfg.data = '0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, both operations, each corner case
        send_req(KIND_ALLOC, '0, '0);
        send_req(KIND_ALLOC, 24'hFFFFFF, 11'h7FF);
        send_req(KIND_ALLOC, 24'd65532, '0);
        send_req(KIND_ALLOC, 24'd65532, '0);
        send_req(KIND_ALLOC, 24'd60, '0);
        send_req(KIND_FREE, '0, 11'd1023);
        send_req(KIND_FREE, '0, 11'd0);
        send_req(KIND_FREE, '0, 11'd2046);
        send_req(KIND_FREE, '0, 11'h7FF);
        send_req(KIND_FREE, '0, 11'd5);
        drain();
        cfg_write(CFG_LEVELS, 24'd0);
        cfg_write(CFG_MINB, 24'd0);
        cfg_write(CFG_MAXREQ, 24'hFFFFFF);
        cfg_write(CFG_UNUSED, 24'h5A5A5A);
        send_req(KIND_ALLOC, 24'd3, '0);
        send_req(KIND_ALLOC, 24'd3, '0);
        send_req(KIND_FREE, '0, 11'd1);
        send_req(KIND_FREE, '0, 11'd0);
        send_req(KIND_ALLOC, 24'hFFFFFB, '0);
        drain();
        cfg_write(CFG_LEVELS, 24'd15);
        cfg_write(CFG_MINB, 24'h1FFFF);
        cfg_write(CFG_MAXREQ, 24'd0);
        send_req(KIND_ALLOC, '0, '0);
        send_req(KIND_FREE, '0, 11'd2046);
        drain();
        cfg_write(CFG_MAXREQ, 24'hFFFFFF);
        send_req(KIND_ALLOC, 24'hFFFFFF, '0);
        send_req(KIND_ALLOC, 24'd100, '0);
        drain();

        // random phases over several settings
        for (int phase = 0; phase < 6; phase++)
        begin
            live_nodes.delete();
            case (phase)
                0: begin cfg_write(CFG_LEVELS, 24'd10); cfg_write(CFG_MINB, 24'd64);
                         cfg_write(CFG_MAXREQ, 24'd65536); end
                1: begin cfg_write(CFG_LEVELS, 24'd3); cfg_write(CFG_MINB, 24'd8);
                         cfg_write(CFG_MAXREQ, 24'd100); end
                2: begin cfg_write(CFG_LEVELS, 24'd12); cfg_write(CFG_MINB, 24'd7);
                         cfg_write(CFG_MAXREQ, 24'd4096); end
                3: begin cfg_write(CFG_LEVELS, 24'($urandom_range(0, 15)));
                         cfg_write(CFG_MINB, 24'($urandom_range(0, 131071)));
                         cfg_write(CFG_MAXREQ, 24'($urandom)); end
                4: begin cfg_write(CFG_LEVELS, 24'd5); cfg_write(CFG_MINB, 24'd65536);
                         cfg_write(CFG_MAXREQ, 24'hFFFFFF); end
                default: begin cfg_write(CFG_LEVELS, 24'd10); cfg_write(CFG_MINB, 24'd16);
                         cfg_write(CFG_MAXREQ, 24'd20000); idle_off = 1'b1; end
            endcase
            if (phase == 1)
                hold_req = 1'b1;
            for (int i = 0; i < 140; i++)
                random_req();
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
sv/bba_pkg.sv
sv/bba_req_if.sv
sv/bba_rsp_if.sv
sv/bba_cfg_if.sv
sv/bba_ram.sv
sv/buddy_bitmap_allocator_top.sv
test/bba_alloc_checker.sv
test/buddy_bitmap_allocator_top_tb.sv
